>>> hdl/assert_macros.svh
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SKF_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("skf assertion failed");

// next-cycle implication, disabled during reset
`define SKF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("skf assertion failed");

`endif

>>> hdl/skf_pkg.sv
package skf_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned MEAS_W        = 16;
  localparam int unsigned TSTEP_W       = 16;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned GAIN_W        = 17;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned OUT_W         = 88;

  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

  localparam logic [TSTEP_W-1:0] TSTEP_RST    = 16'd1280;
  localparam logic [WORD_W-1:0]  INIT_EST_RST = 32'd1048576;
  localparam logic [WORD_W-1:0]  INIT_VAR_RST = 32'd6553600;
  localparam logic [WORD_W-1:0]  MEAS_VAR_RST = 32'd1048576;
  localparam logic [WORD_W-1:0]  PROC_VAR_RST = 32'd65536;
  localparam logic [WORD_W-1:0]  RATE_RST     = 32'd0;
  localparam logic [WORD_W-1:0]  RATE_VAR_RST = 32'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP = 3'd0,
    CFG_INIT_EST  = 3'd1,
    CFG_INIT_VAR  = 3'd2,
    CFG_MEAS_VAR  = 3'd3,
    CFG_PROC_VAR  = 3'd4,
    CFG_RATE      = 3'd5,
    CFG_RATE_VAR  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

endpackage

>>> hdl/scalar_kalman_filter_top.sv
// channel    direction  handshake                       payload
// s_axis     in         s_axis_tvalid / s_axis_tready   tdata: measurement, tuser: restart
// m_axis     out        m_axis_tvalid / m_axis_tready   tdata: estimate, variance, gain
// cfg        in         cfg_valid_i / cfg_ready_o       cfg_index_i, cfg_data_i
//
// one request at a time: the result is written to the output register, and the next
// request is taken once the filter is back in idle
// after load, the gain divider retires one quotient bit per cycle, then the two gain
// products run one gain bit per cycle, followed by two add stages and output
// reset loads the configuration defaults and the initial estimate and variance
// a stalled result waits in the output register while the next request is processed
`include "assert_macros.svh"

module scalar_kalman_filter_top #(
  parameter int unsigned FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [skf_pkg::MEAS_W-1:0]         s_axis_tdata,   // measurement
  input  logic [0:0]                         s_axis_tuser,   // restart
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [skf_pkg::OUT_W-1:0]          m_axis_tdata,   // estimate, variance, gain, zeros
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [skf_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [skf_pkg::WORD_W-1:0]         cfg_data_i
);

  localparam int unsigned WW    = skf_pkg::WORD_W;
  localparam int unsigned TW    = skf_pkg::TSTEP_W;
  localparam int unsigned GW    = skf_pkg::GAIN_W;
  localparam int unsigned MX_W  = WW + 2;
  localparam int unsigned TR_AW = WW;
  localparam int unsigned TV1_AW = WW + 1;
  localparam int unsigned TV2_AW = TV1_AW + TW;
  localparam int unsigned KX_AW = MX_W;
  localparam int unsigned KP_AW = WW + 1;
  localparam int unsigned SE_W  = 42;
  localparam int unsigned SP_W  = 49;
  localparam int unsigned PAD_W = skf_pkg::OUT_W - 2 * WW - GW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_DIV,
    S_MUL,
    S_SUM,
    S_FIN,
    S_OUT
  } state_e;

  state_e state_q;

  logic [TW-1:0] tstep_q;
  logic [WW-1:0] init_est_q, init_var_q, meas_var_q, proc_var_q, rate_q, rate_var_q;

  logic [WW-1:0]             x_q, p_q;
  logic [skf_pkg::MEAS_W-1:0] m_q;
  logic [GW-1:0]             k_q;
  logic [SE_W-1:0]           se_q;
  logic [SP_W-1:0]           sp_q;

  logic                      out_valid_q;
  logic [WW-1:0]             out_est_q, out_var_q;
  logic [GW-1:0]             out_gain_q;

  skf_pkg::seq_stat_t div_stat, tr_stat, tv1_stat, tv2_stat, kx_stat, kp_stat;

  logic [GW-1:0]             div_quo;
  logic [TR_AW+TW-1:0]       tr_prod;
  logic [TV1_AW+TW-1:0]      tv1_prod;
  logic [TV2_AW+TW-1:0]      tv2_prod;
  logic [KX_AW+GW-1:0]       kx_prod;
  logic [KP_AW+GW-1:0]       kp_prod;

  logic                      load;
  logic [WW:0]               den;
  logic [MX_W-1:0]           m_ext, mx;
  logic [SE_W-1:0]           e_full;
  logic [WW-1:0]             e_sat;
  logic [SP_W:0]             pv_full;
  logic [WW-1:0]             pv_sat;

  assign load  = (state_q == S_LOAD);
  assign den   = {1'b0, p_q} + {1'b0, meas_var_q};
  assign m_ext = MX_W'(m_q) << (FRAC_BITS - 8);
  assign mx    = m_ext - {{(MX_W-WW){x_q[WW-1]}}, x_q};

  skf_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load),
    .num_i   (p_q),
    .den_i   (den),
    .quo_o   (div_quo),
    .stat_o  (div_stat)
  );

  // t * rate
  skf_mul #(.AW(TR_AW), .BW(TW)) u_mul_tr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load),
    .a_i     (rate_q),
    .b_i     (tstep_q),
    .prod_o  (tr_prod),
    .stat_o  (tr_stat)
  );

  // rate_variance * t, then times t again
  skf_mul #(.AW(TV1_AW), .BW(TW)) u_mul_tv1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load),
    .a_i     ({1'b0, rate_var_q}),
    .b_i     (tstep_q),
    .prod_o  (tv1_prod),
    .stat_o  (tv1_stat)
  );

  skf_mul #(.AW(TV2_AW), .BW(TW)) u_mul_tv2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (tv1_stat.done),
    .a_i     (tv1_prod),
    .b_i     (tstep_q),
    .prod_o  (tv2_prod),
    .stat_o  (tv2_stat)
  );

  // k * (m - x)
  skf_mul #(.AW(KX_AW), .BW(GW)) u_mul_kx (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_stat.done),
    .a_i     (mx),
    .b_i     (div_quo),
    .prod_o  (kx_prod),
    .stat_o  (kx_stat)
  );

  // (1 - k) * p
  skf_mul #(.AW(KP_AW), .BW(GW)) u_mul_kp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_stat.done),
    .a_i     ({1'b0, p_q}),
    .b_i     (skf_pkg::GAIN_ONE - div_quo),
    .prod_o  (kp_prod),
    .stat_o  (kp_stat)
  );

  // final adds with saturation
  always_comb begin
    e_full  = se_q + {{(SE_W-35){kx_prod[KX_AW+GW-1]}}, kx_prod[KX_AW+GW-1:16]};
    if ((&e_full[SE_W-1:WW-1]) || !(|e_full[SE_W-1:WW-1])) begin
      e_sat = e_full[WW-1:0];
    end else if (e_full[SE_W-1]) begin
      e_sat = 32'h8000_0000;
    end else begin
      e_sat = 32'h7fff_ffff;
    end
    pv_full = {1'b0, sp_q} + (SP_W+1)'(proc_var_q);
    pv_sat  = (|pv_full[SP_W:WW]) ? '1 : pv_full[WW-1:0];
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tstep_q    <= skf_pkg::TSTEP_RST;
      init_est_q <= skf_pkg::INIT_EST_RST;
      init_var_q <= skf_pkg::INIT_VAR_RST;
      meas_var_q <= skf_pkg::MEAS_VAR_RST;
      proc_var_q <= skf_pkg::PROC_VAR_RST;
      rate_q     <= skf_pkg::RATE_RST;
      rate_var_q <= skf_pkg::RATE_VAR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (skf_pkg::cfg_idx_e'(cfg_index_i))
        skf_pkg::CFG_TIME_STEP: tstep_q    <= cfg_data_i[TW-1:0];
        skf_pkg::CFG_INIT_EST:  init_est_q <= cfg_data_i;
        skf_pkg::CFG_INIT_VAR:  init_var_q <= cfg_data_i;
        skf_pkg::CFG_MEAS_VAR:  meas_var_q <= cfg_data_i;
        skf_pkg::CFG_PROC_VAR:  proc_var_q <= cfg_data_i;
        skf_pkg::CFG_RATE:      rate_q     <= cfg_data_i;
        skf_pkg::CFG_RATE_VAR:  rate_var_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      x_q         <= skf_pkg::INIT_EST_RST;
      p_q         <= skf_pkg::INIT_VAR_RST;
      m_q         <= '0;
      k_q         <= '0;
      se_q        <= '0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
      out_est_q   <= '0;
      out_var_q   <= '0;
      out_gain_q  <= '0;
    end else begin
      if (out_valid_q && m_axis_tready && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            m_q <= s_axis_tdata;
            if (s_axis_tuser[0]) begin
              x_q <= init_est_q;
              p_q <= init_var_q;
            end
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_stat.done) begin
            k_q     <= div_quo;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          if (kx_stat.done) begin
            state_q <= S_SUM;
          end
        end
        S_SUM: begin
          se_q    <= {{(SE_W-WW){x_q[WW-1]}}, x_q}
                   + {{(SE_W-40){tr_prod[TR_AW+TW-1]}}, tr_prod[TR_AW+TW-1:8]};
          sp_q    <= SP_W'(kp_prod[47:16]) + SP_W'(tv2_prod[63:16]);
          state_q <= S_FIN;
        end
        S_FIN: begin
          x_q     <= e_sat;
          p_q     <= pv_sat;
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            out_est_q   <= x_q;
            out_var_q   <= p_q;
            out_gain_q  <= k_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_gain_q, out_var_q, out_est_q};

  // all units that start from the latched state are running the cycle after load
  `SKF_ASSERT_NEXT(a_units_run, load, div_stat.busy && tr_stat.busy && tv1_stat.busy)
  // the rate variance chain has finished before the gain products complete
  `SKF_ASSERT(a_tv_first, kx_stat.done, !tv1_stat.busy && !tv2_stat.busy && kp_stat.done)
  // the gain never exceeds one
  `SKF_ASSERT(a_gain_range, state_q == S_OUT, k_q <= skf_pkg::GAIN_ONE)

endmodule

>>> hdl/skf_div.sv
module skf_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [skf_pkg::WORD_W-1:0]      num_i,
  input  logic [skf_pkg::WORD_W:0]        den_i,
  output logic [skf_pkg::GAIN_W-1:0]      quo_o,
  output skf_pkg::seq_stat_t              stat_o
);

  localparam int unsigned RW = skf_pkg::WORD_W + 2;
  localparam int unsigned CW = $clog2(skf_pkg::GAIN_W + 1);

  logic [RW-1:0]                 rem_q, rem_d;
  logic [skf_pkg::WORD_W:0]      den_q;
  logic [skf_pkg::GAIN_W-1:0]    quo_q, quo_d;
  logic [CW-1:0]                 cnt_q;
  logic                          first_q;
  logic                          zero_q;
  logic                          done_q;
  logic [RW-1:0]                 trial;
  logic [RW:0]                   diff;
  logic                          ge;

  // first digit compares the numerator as is, later digits shift the remainder
  always_comb begin
    trial = first_q ? rem_q : {rem_q[RW-2:0], 1'b0};
    diff  = {1'b0, trial} - {2'b00, den_q};
    ge    = !diff[RW];
    rem_d = ge ? diff[RW-1:0] : trial;
    quo_d = {quo_q[skf_pkg::GAIN_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      first_q <= 1'b0;
      zero_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q   <= CW'(skf_pkg::GAIN_W);
        first_q <= 1'b1;
        zero_q  <= (den_i == '0);
      end else if (cnt_q != '0) begin
        cnt_q   <= cnt_q - CW'(1);
        first_q <= 1'b0;
        done_q  <= (cnt_q == CW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= RW'(num_i);
      den_q <= den_i;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // zero denominator gives zero gain
  assign quo_o       = zero_q ? '0 : quo_q;
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

>>> hdl/skf_mul.sv
module skf_mul #(
  parameter int unsigned AW = 32,
  parameter int unsigned BW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [AW-1:0]        a_i,
  input  logic [BW-1:0]        b_i,
  output logic [AW+BW-1:0]     prod_o,
  output skf_pkg::seq_stat_t   stat_o
);

  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW-1:0] a_q;
  logic [AW:0]   hi_q;
  logic [BW-1:0] lo_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [AW:0]   addend;
  logic [AW:0]   sum;

  // a is two's complement, b unsigned, one bit of b per cycle
  always_comb begin
    addend = lo_q[0] ? {a_q[AW-1], a_q} : '0;
    sum    = hi_q + addend;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(BW);
      end else if (cnt_q != '0) begin
        cnt_q  <= cnt_q - CW'(1);
        done_q <= (cnt_q == CW'(1));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q  <= a_i;
      hi_q <= '0;
      lo_q <= b_i;
    end else if (cnt_q != '0) begin
      hi_q <= {sum[AW], sum[AW:1]};
      lo_q <= {sum[0], lo_q[BW-1:1]};
    end
  end

  assign prod_o      = {hi_q[AW-1:0], lo_q};
  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [skf_pkg::CFG_IDX_W-1:0] CFG_NONE = 3'd7;
  localparam longint EST_MAX = 2147483647;
  localparam longint EST_MIN = -EST_MAX - 1;
  localparam int unsigned RANDOM_REQS = 1300;

  typedef struct packed {
    logic [skf_pkg::GAIN_W-1:0] gain;
    logic [skf_pkg::WORD_W-1:0] variance;
    logic [skf_pkg::WORD_W-1:0] estimate;
  } filt_out_t;

  typedef struct {
    bit                            is_cfg;
    logic [skf_pkg::CFG_IDX_W-1:0] idx;
    logic [skf_pkg::WORD_W-1:0]    data;
    logic [skf_pkg::MEAS_W-1:0]    meas;
    logic                          restart;
    bit                            known;
    filt_out_t                     want;
  } dir_row_t;

  logic                          clk_i;
  logic                          rst_ni         = 1'b0;
  logic                          s_axis_tvalid  = 1'b0;
  logic                          s_axis_tready;
  logic [skf_pkg::MEAS_W-1:0]    s_axis_tdata   = '0;  // measurement
  logic [0:0]                    s_axis_tuser   = '0;  // restart
  logic                          m_axis_tvalid;
  logic                          m_axis_tready  = 1'b0;
  logic [skf_pkg::OUT_W-1:0]     m_axis_tdata;         // estimate, variance, gain, zeros
  logic                          cfg_valid_i    = 1'b0;
  logic                          cfg_ready_o;
  logic [skf_pkg::CFG_IDX_W-1:0] cfg_index_i    = '0;
  logic [skf_pkg::WORD_W-1:0]    cfg_data_i     = '0;

  scalar_kalman_filter_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // filter registers and state as the testbench sees them
  logic [skf_pkg::TSTEP_W-1:0]       tstep_r    = skf_pkg::TSTEP_RST;
  logic signed [skf_pkg::WORD_W-1:0] init_est_r = skf_pkg::INIT_EST_RST;
  logic [skf_pkg::WORD_W-1:0]        init_var_r = skf_pkg::INIT_VAR_RST;
  logic [skf_pkg::WORD_W-1:0]        meas_var_r = skf_pkg::MEAS_VAR_RST;
  logic [skf_pkg::WORD_W-1:0]        proc_var_r = skf_pkg::PROC_VAR_RST;
  logic signed [skf_pkg::WORD_W-1:0] rate_r     = skf_pkg::RATE_RST;
  logic [skf_pkg::WORD_W-1:0]        rate_var_r = skf_pkg::RATE_VAR_RST;
  logic signed [skf_pkg::WORD_W-1:0] est_q      = skf_pkg::INIT_EST_RST;
  logic [skf_pkg::WORD_W-1:0]        var_q      = skf_pkg::INIT_VAR_RST;

  filt_out_t   pending_updates[$];
  dir_row_t    dir_rows[$];
  int unsigned reqs_sent, restarts, cfg_writes, settings, results_seen;
  int unsigned est_clips, var_clips, mismatches;
  int unsigned burst_left, rx_mode, rx_mode_left;
  bit          held;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic filt_out_t kalman_update(input logic [skf_pkg::MEAS_W-1:0] meas,
                                              input logic restart);
    filt_out_t          res;
    longint             x, m, e, ks, ts;
    longint unsigned    p, den, k, t, pv;
    if (restart) begin
      est_q = init_est_r;
      var_q = init_var_r;
    end
    x   = est_q;
    p   = var_q;
    den = p + meas_var_r;
    k   = (den == 0) ? 64'd0 : (p << 16) / den;
    t   = tstep_r;
    ks  = k;
    ts  = t;
    m   = meas;
    m   = m <<< 8;
    e   = x + ((ts * rate_r) >>> 8) + ((ks * (m - x)) >>> 16);
    if (e > EST_MAX || e < EST_MIN) est_clips++;
    if (e > EST_MAX) e = EST_MAX;
    if (e < EST_MIN) e = EST_MIN;
    pv = (((64'd65536 - k) * p) >> 16) + ((t * t * rate_var_r) >> 16) + proc_var_r;
    if (pv > 64'hFFFF_FFFF) begin
      pv = 64'hFFFF_FFFF;
      var_clips++;
    end
    est_q        = e[31:0];
    var_q        = pv[31:0];
    res.estimate = est_q;
    res.variance = var_q;
    res.gain     = k[16:0];
    return res;
  endfunction

  function automatic logic [skf_pkg::WORD_W-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void row_cfg(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [skf_pkg::WORD_W-1:0] data);
    dir_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_req(input logic [skf_pkg::MEAS_W-1:0] meas, input logic restart,
                                  input bit known = 1'b0, input logic [31:0] est = '0,
                                  input logic [31:0] variance = '0,
                                  input logic [16:0] gain = '0);
    dir_row_t r;
    r         = '{default: '0};
    r.meas    = meas;
    r.restart = restart;
    r.known   = known;
    r.want    = '{gain: gain, variance: variance, estimate: est};
    dir_rows.push_back(r);
  endfunction

  task automatic cfg_write(input logic [skf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [skf_pkg::WORD_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      skf_pkg::CFG_TIME_STEP: tstep_r    = data[skf_pkg::TSTEP_W-1:0];
      skf_pkg::CFG_INIT_EST:  init_est_r = data;
      skf_pkg::CFG_INIT_VAR:  init_var_r = data;
      skf_pkg::CFG_MEAS_VAR:  meas_var_r = data;
      skf_pkg::CFG_PROC_VAR:  proc_var_r = data;
      skf_pkg::CFG_RATE:      rate_r     = data;
      skf_pkg::CFG_RATE_VAR:  rate_var_r = data;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk_i);
  endtask

  task automatic offer(input logic [skf_pkg::MEAS_W-1:0] meas, input logic restart,
                       input bit known, input filt_out_t want);
    filt_out_t  pred;
    int unsigned gap;
    s_axis_tdata  <= meas;
    s_axis_tuser  <= restart;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = kalman_update(meas, restart);
    pending_updates.push_back(known ? want : pred);
    reqs_sent++;
    if (restart) restarts++;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7:       gap = $urandom_range(1, 4);
        default:       gap = $urandom_range(5, 50);
      endcase
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase(input bit wild);
    int unsigned                n;
    logic [skf_pkg::WORD_W-1:0] w;
    logic [skf_pkg::MEAS_W-1:0] meas;
    logic                       restart;
    bit                         first;
    drain();
    if (wild) begin
      cfg_write(skf_pkg::CFG_TIME_STEP, rand_word());
      cfg_write(skf_pkg::CFG_INIT_EST, rand_word());
      cfg_write(skf_pkg::CFG_INIT_VAR, rand_word());
      w = rand_word();
      cfg_write(skf_pkg::CFG_MEAS_VAR, (w == 0) ? 32'd1 : w);
      cfg_write(skf_pkg::CFG_PROC_VAR, rand_word());
      cfg_write(skf_pkg::CFG_RATE, rand_word());
      cfg_write(skf_pkg::CFG_RATE_VAR, rand_word());
    end else begin
      cfg_write(skf_pkg::CFG_TIME_STEP, $urandom_range(16, 2560));
      cfg_write(skf_pkg::CFG_INIT_EST, $urandom_range(0, 200 << 16));
      cfg_write(skf_pkg::CFG_INIT_VAR, $urandom_range(1 << 12, 1000 << 16));
      cfg_write(skf_pkg::CFG_MEAS_VAR, $urandom_range(1 << 10, 100 << 16));
      cfg_write(skf_pkg::CFG_PROC_VAR, $urandom_range(0, 4 << 16));
      cfg_write(skf_pkg::CFG_RATE, 32'($urandom_range(0, 2 << 16)) - 32'd65536);
      cfg_write(skf_pkg::CFG_RATE_VAR, $urandom_range(0, 1 << 14));
    end
    if ($urandom_range(0, 3) == 0) cfg_write(CFG_NONE, $urandom);
    settings++;
    n     = $urandom_range(80, 160);
    first = 1'b1;
    repeat (n) begin
      meas    = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 51200));
      restart = ($urandom_range(0, 19) == 0) || (first && $urandom_range(0, 3) != 0);
      offer(meas, restart, 1'b0, '0);
      first = 1'b0;
    end
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] want,
                               input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at result %0d: %s expected %h got %h", results_seen, field, want, got);
  endtask

  task automatic check_result(input logic [skf_pkg::OUT_W-1:0] data);
    filt_out_t got, want;
    got = data[$bits(filt_out_t)-1:0];
    results_seen++;
    if (pending_updates.size() == 0) begin
      note_mismatch("unexpected result, estimate", '0, got.estimate);
    end else begin
      want = pending_updates.pop_front();
      if (got.estimate !== want.estimate) note_mismatch("estimate", want.estimate, got.estimate);
      if (got.variance !== want.variance) note_mismatch("variance", want.variance, got.variance);
      if (got.gain !== want.gain) note_mismatch("gain", 32'(want.gain), 32'(got.gain));
    end
  endtask

  // result side: randomly chosen stall patterns, one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
      if (!held && results_seen == 200) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = $urandom_range(0, 3);
          rx_mode_left = 128;
        end
        rx_mode_left--;
        case (rx_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= 1'($urandom_range(0, 1));
          2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin
    row_req(16'h1000, 1'b0, 1'b1, 32'h0010_0000, 32'd969536, 17'd56496);
    row_req(16'h0000, 1'b0);
    row_req(16'd51200, 1'b0);
    row_req(16'hFFFF, 1'b1);
    row_req(16'h8000, 1'b0);
    // initial estimate write must not touch the running state
    row_cfg(skf_pkg::CFG_INIT_EST, 32'h7FFF_FFFF);
    row_req(16'h1000, 1'b0);
    row_cfg(skf_pkg::CFG_TIME_STEP, 32'h0000_FFFF);
    row_cfg(skf_pkg::CFG_INIT_VAR, 32'hFFFF_FFFF);
    row_cfg(skf_pkg::CFG_MEAS_VAR, 32'hFFFF_FFFF);
    row_cfg(skf_pkg::CFG_PROC_VAR, 32'hFFFF_FFFF);
    row_cfg(skf_pkg::CFG_RATE, 32'h7FFF_FFFF);
    row_req(16'hFFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 17'd32768);
    row_cfg(skf_pkg::CFG_RATE_VAR, 32'hFFFF_FFFF);
    row_req(16'h0000, 1'b0);
    row_cfg(skf_pkg::CFG_INIT_EST, 32'h8000_0000);
    row_cfg(skf_pkg::CFG_RATE, 32'h8000_0000);
    row_req(16'h0000, 1'b1, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 17'd32768);
    row_req(16'd51200, 1'b0);
    // out of range index is dropped
    row_cfg(CFG_NONE, 32'hFFFF_FFFF);
    row_cfg(skf_pkg::CFG_TIME_STEP, 32'h0);
    row_cfg(skf_pkg::CFG_INIT_EST, 32'h0);
    row_cfg(skf_pkg::CFG_INIT_VAR, 32'h0);
    row_cfg(skf_pkg::CFG_MEAS_VAR, 32'h1);
    row_cfg(skf_pkg::CFG_PROC_VAR, 32'h0);
    row_cfg(skf_pkg::CFG_RATE, 32'h0);
    row_cfg(skf_pkg::CFG_RATE_VAR, 32'h0);
    row_req(16'h0000, 1'b1, 1'b1, 32'h0, 32'h0, 17'd0);
    row_req(16'd51200, 1'b0, 1'b1, 32'h0, 32'h0, 17'd0);
    row_cfg(skf_pkg::CFG_PROC_VAR, 32'h0001_0000);
    row_cfg(skf_pkg::CFG_INIT_VAR, 32'hFFFF_FFFF);
    row_req(16'd51200, 1'b1);
    row_req(16'h0000, 1'b0);
    row_cfg(skf_pkg::CFG_TIME_STEP, 32'd1280);
    row_cfg(skf_pkg::CFG_INIT_EST, 32'd1048576);
    row_cfg(skf_pkg::CFG_INIT_VAR, 32'd6553600);
    row_cfg(skf_pkg::CFG_MEAS_VAR, 32'd1048576);
    row_cfg(skf_pkg::CFG_PROC_VAR, 32'd65536);
    row_cfg(skf_pkg::CFG_RATE, 32'h0001_8000);
    row_cfg(skf_pkg::CFG_RATE_VAR, 32'h0000_4000);
    row_req(16'h1400, 1'b1);
    row_req(16'h1480, 1'b0);
    row_req(16'h7F7F, 1'b0);
    row_req(16'h0001, 1'b0);
    row_req(16'hFFFE, 1'b0);

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    settings = 1;
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        cfg_write(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        offer(dir_rows[i].meas, dir_rows[i].restart, dir_rows[i].known, dir_rows[i].want);
      end
    end

    while (reqs_sent < RANDOM_REQS)
      random_phase($urandom_range(0, 3) == 0);

    drain();
    repeat (50) @(posedge clk_i);
    $display("covered %0d requests (%0d with restart) under %0d register settings, %0d writes",
             reqs_sent, restarts, settings, cfg_writes);
    $display("checked %0d results, %0d estimate clips, %0d variance clips, %0d mismatches",
             results_seen, est_clips, var_clips, mismatches);
    if (mismatches == 0 && pending_updates.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/skf_pkg.sv
hdl/skf_div.sv
hdl/skf_mul.sv
hdl/scalar_kalman_filter_top.sv
test/tb.sv
